>>> rtl/core/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine: request kinds,
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Request kinds (input field "kind")
    localparam logic [2:0] KIND_APPEND   = 3'd0;
    localparam logic [2:0] KIND_INSERT   = 3'd1;
    localparam logic [2:0] KIND_REM_TAIL = 3'd2;
    localparam logic [2:0] KIND_REM_AT   = 3'd3;
    localparam logic [2:0] KIND_RD_HEAD  = 3'd4;
    localparam logic [2:0] KIND_RD_TAIL  = 3'd5;
    localparam logic [2:0] KIND_CLEAR    = 3'd6;

    // Result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_BADPOS = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    // Field widths and stream packing
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 7;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    typedef enum logic [2:0] {
        OPC_NONE,
        OPC_INSERT,
        OPC_REMOVE,
        OPC_READ,
        OPC_CLEAR
    } op_class_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_GOT,
        S_INS_LOOP,
        S_INS_WR,
        S_REM_LOOP,
        S_REM_WR,
        S_FINISH
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic latch_status;
        logic got_clr;
        logic got_load;
        logic cur_load_len;
        logic cur_load_tgt;
        logic cur_inc;
        logic cur_dec;
        logic mem_rd;
        logic rd_prev;
        logic rd_next;
        logic mem_wr;
        logic wr_value;
        logic len_inc;
        logic len_dec;
        logic len_clr;
        logic out_load;
    } ple_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        op_class_t op_class;
        logic      err;
        logic      at_tgt;
        logic      rem_end;
        logic      out_free;
    } ple_stat_t;

endpackage

>>> rtl/core/positional_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list of up to DEPTH signed 32-bit values with positional
// insert, remove and read requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream; each transfer carries a kind (append,
//   insert, remove tail, remove at, read from head, read from tail, clear),
//   a value and a position. Every request yields exactly one result transfer
//   on the m_ stream: the value read or removed (zero otherwise), a status
//   (ok, empty, bad position, full) and the list length after the request.
//   Each request is captured and then checked. Errors, clears and unused
//   kinds then go on to the result; appends write the entry, reads fetch
//   it, tail removals fetch it and then drop the length, before the result.
//   Insert at position p moves the (length - p) entries behind it one slot
//   up and remove at p moves the (length - p - 1) entries behind it down,
//   each moved entry read, then written, through the single entry memory.
//   One request is in work at a time; the next is taken once the result is
//   in the output register.
//   Reset (aresetn low, synchronous) empties the list and drops any pending
//   result; stored entries are not cleared. When the receiver stalls, the
//   result holds in the output register; the engine still takes and works
//   the following request and holds its result until the old one is taken.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
    parameter int DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [2:0] kind, [34:3] value, [41:35] position, [47:42] zero
    input  logic [ple_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [31:0] read_value, [33:32] status, [40:34] length, [47:41] zero
    output logic [ple_pkg::M_DATA_W-1:0] m_tdata
);

    ple_pkg::ple_cmd_t  cmd;
    ple_pkg::ple_stat_t stat;

    // Sequencer: one request at a time, shift loops over the entry memory
    ple_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage, length and cursor, request checks, result register
    ple_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

>>> rtl/core/ple_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer for the list engine: decodes the checked request and steps the
// datapath through entry shifts, fetches and the result transfer.
// ----------------------------------------------------------------------------
module ple_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ple_pkg::ple_stat_t stat,
    output ple_pkg::ple_cmd_t  cmd
);

    ple_pkg::state_t state_reg;
    ple_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ple_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ple_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = ple_pkg::S_CHECK;
                end
            end
            ple_pkg::S_CHECK: begin
                if (stat.err) begin
                    state_next = ple_pkg::S_FINISH;
                end else begin
                    case (stat.op_class)
                        ple_pkg::OPC_INSERT: state_next = ple_pkg::S_INS_LOOP;
                        ple_pkg::OPC_REMOVE,
                        ple_pkg::OPC_READ:   state_next = ple_pkg::S_GOT;
                        default:             state_next = ple_pkg::S_FINISH;
                    endcase
                end
            end
            ple_pkg::S_GOT: begin
                if (stat.op_class == ple_pkg::OPC_REMOVE) begin
                    state_next = ple_pkg::S_REM_LOOP;
                end else begin
                    state_next = ple_pkg::S_FINISH;
                end
            end
            ple_pkg::S_INS_LOOP: begin
                state_next = stat.at_tgt ? ple_pkg::S_FINISH : ple_pkg::S_INS_WR;
            end
            ple_pkg::S_INS_WR: begin
                state_next = ple_pkg::S_INS_LOOP;
            end
            ple_pkg::S_REM_LOOP: begin
                state_next = stat.rem_end ? ple_pkg::S_FINISH : ple_pkg::S_REM_WR;
            end
            ple_pkg::S_REM_WR: begin
                state_next = ple_pkg::S_REM_LOOP;
            end
            ple_pkg::S_FINISH: begin
                if (stat.out_free) begin
                    state_next = ple_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ple_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ple_pkg::S_CHECK: begin
                cmd.latch_status = 1'b1;
                cmd.got_clr      = 1'b1;
                if (!stat.err) begin
                    case (stat.op_class)
                        ple_pkg::OPC_INSERT: cmd.cur_load_len = 1'b1;
                        ple_pkg::OPC_REMOVE,
                        ple_pkg::OPC_READ:   cmd.mem_rd = 1'b1;
                        ple_pkg::OPC_CLEAR:  cmd.len_clr = 1'b1;
                        default:             cmd.mem_rd = 1'b0;
                    endcase
                end
            end
            ple_pkg::S_GOT: begin
                cmd.got_load     = 1'b1;
                cmd.cur_load_tgt = (stat.op_class == ple_pkg::OPC_REMOVE);
            end
            ple_pkg::S_INS_LOOP: begin
                if (stat.at_tgt) begin
                    // drop the new value into the opened slot
                    cmd.mem_wr   = 1'b1;
                    cmd.wr_value = 1'b1;
                    cmd.len_inc  = 1'b1;
                end else begin
                    cmd.mem_rd  = 1'b1;
                    cmd.rd_prev = 1'b1;
                end
            end
            ple_pkg::S_INS_WR: begin
                cmd.mem_wr  = 1'b1;
                cmd.cur_dec = 1'b1;
            end
            ple_pkg::S_REM_LOOP: begin
                if (stat.rem_end) begin
                    cmd.len_dec = 1'b1;
                end else begin
                    cmd.mem_rd  = 1'b1;
                    cmd.rd_next = 1'b1;
                end
            end
            ple_pkg::S_REM_WR: begin
                cmd.mem_wr  = 1'b1;
                cmd.cur_inc = 1'b1;
            end
            ple_pkg::S_FINISH: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/ple_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_datapath
// Entry memory, length and cursor registers, request checks and the result
// output register of the list engine.
// ----------------------------------------------------------------------------
module ple_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [ple_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ple_pkg::M_DATA_W-1:0]   m_tdata,
    input  ple_pkg::ple_cmd_t              cmd,
    output ple_pkg::ple_stat_t             stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > ple_pkg::POS_W) ? LW : ple_pkg::POS_W;
    localparam int XW = CW + 1;

    logic [ple_pkg::KIND_W-1:0]  kind_reg;
    logic [ple_pkg::VALUE_W-1:0] value_reg;
    logic [ple_pkg::POS_W-1:0]   pos_reg;
    logic [LW-1:0]               len_reg;
    logic [LW-1:0]               cur_reg;
    logic [ple_pkg::VALUE_W-1:0] rdata_reg;
    logic [ple_pkg::VALUE_W-1:0] got_reg;
    logic [ple_pkg::STAT_W-1:0]  status_reg;
    logic                        m_valid_reg;
    logic [ple_pkg::M_DATA_W-1:0] m_data_reg;

    logic [ple_pkg::VALUE_W-1:0] mem [DEPTH];

    logic [XW-1:0]              posx;
    logic [XW-1:0]              lenx;
    logic [XW-1:0]              curx;
    logic [XW-1:0]              tgtx;
    logic                       full;
    logic                       empty;
    logic [ple_pkg::STAT_W-1:0] code;
    ple_pkg::op_class_t         op_class;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [ple_pkg::VALUE_W-1:0] wr_data;

    assign posx  = XW'(pos_reg);
    assign lenx  = XW'(len_reg);
    assign curx  = XW'(cur_reg);
    assign full  = (lenx == XW'(DEPTH));
    assign empty = (len_reg == '0);

    // Check the request against the current length and pick its target slot
    always_comb begin
        code     = ple_pkg::STAT_OK;
        op_class = ple_pkg::OPC_NONE;
        tgtx     = posx;
        case (kind_reg)
            ple_pkg::KIND_APPEND: begin
                op_class = ple_pkg::OPC_INSERT;
                tgtx     = lenx;
                if (full) code = ple_pkg::STAT_FULL;
            end
            ple_pkg::KIND_INSERT: begin
                op_class = ple_pkg::OPC_INSERT;
                if (posx > lenx)  code = ple_pkg::STAT_BADPOS;
                else if (full)    code = ple_pkg::STAT_FULL;
            end
            ple_pkg::KIND_REM_TAIL: begin
                op_class = ple_pkg::OPC_REMOVE;
                tgtx     = lenx - XW'(1);
                if (empty) code = ple_pkg::STAT_EMPTY;
            end
            ple_pkg::KIND_REM_AT: begin
                op_class = ple_pkg::OPC_REMOVE;
                if (empty)              code = ple_pkg::STAT_EMPTY;
                else if (posx >= lenx)  code = ple_pkg::STAT_BADPOS;
            end
            ple_pkg::KIND_RD_HEAD: begin
                op_class = ple_pkg::OPC_READ;
                if (empty)              code = ple_pkg::STAT_EMPTY;
                else if (posx >= lenx)  code = ple_pkg::STAT_BADPOS;
            end
            ple_pkg::KIND_RD_TAIL: begin
                op_class = ple_pkg::OPC_READ;
                tgtx     = lenx - XW'(1) - posx;
                if (empty)              code = ple_pkg::STAT_EMPTY;
                else if (posx >= lenx)  code = ple_pkg::STAT_BADPOS;
            end
            ple_pkg::KIND_CLEAR: begin
                op_class = ple_pkg::OPC_CLEAR;
            end
            default: begin
                op_class = ple_pkg::OPC_NONE;
            end
        endcase
    end

    assign stat.op_class = op_class;
    assign stat.err      = (code != ple_pkg::STAT_OK);
    assign stat.at_tgt   = (curx == tgtx);
    assign stat.rem_end  = ((curx + XW'(1)) >= lenx);
    assign stat.out_free = !m_valid_reg || m_tready;

    // Memory addressing
    always_comb begin
        if (cmd.rd_prev) begin
            rd_addr = AW'(curx - XW'(1));
        end else if (cmd.rd_next) begin
            rd_addr = AW'(curx + XW'(1));
        end else begin
            rd_addr = tgtx[AW-1:0];
        end
    end

    assign wr_addr = cur_reg[AW-1:0];
    assign wr_data = cmd.wr_value ? value_reg : rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Request and work registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= s_tdata[2:0];
            value_reg <= s_tdata[34:3];
            pos_reg   <= s_tdata[41:35];
        end
        if (cmd.latch_status) begin
            status_reg <= code;
        end
        if (cmd.got_clr) begin
            got_reg <= '0;
        end else if (cmd.got_load) begin
            got_reg <= rdata_reg;
        end
        if (cmd.cur_load_len) begin
            cur_reg <= len_reg;
        end else if (cmd.cur_load_tgt) begin
            cur_reg <= tgtx[LW-1:0];
        end else if (cmd.cur_inc) begin
            cur_reg <= cur_reg + LW'(1);
        end else if (cmd.cur_dec) begin
            cur_reg <= cur_reg - LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cmd.len_clr) begin
            len_reg <= '0;
        end else if (cmd.len_inc) begin
            len_reg <= len_reg + LW'(1);
        end else if (cmd.len_dec) begin
            len_reg <= len_reg - LW'(1);
        end
    end

    // Result register: hold until the downstream side takes the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {7'd0, lenx[ple_pkg::LEN_W-1:0], status_reg, got_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> test/positional_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit_tb
// Self-checking bench for the positional list engine. A short table of
// directed requests covers the empty, bad-position and boundary cases. Random
// fill, drain, mixed and noise phases then drive the list to full and back to
// empty many times. Each result is checked field by field against a list
// model or a typed row. Both stream sides idle at random between transfers.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;

    localparam int DEPTH = 64;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 10;
    // kind 7 has no name in the package; the engine treats it as a no-op
    localparam logic [2:0] KIND_NOP = 3'd7;

    typedef struct packed {
        logic [31:0] rd_val;
        logic [1:0]  stat;
        logic [6:0]  len;
    } list_result_t;

    typedef struct packed {
        logic [2:0]   kind;
        logic [31:0]  value;
        logic [6:0]   pos;
        logic         typed;    // expected result given in the row itself
        list_result_t want;
    } request_row_t;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX, PH_NOISE} phase_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [ple_pkg::S_DATA_W-1:0]  s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ple_pkg::M_DATA_W-1:0]  m_tdata;

    // model state: entries packed from the head at index 0
    logic [31:0]           list_mem [DEPTH];
    int                    list_len = 0;

    list_result_t          pending_results [$];
    request_row_t          request_table [$];

    int                    errors = 0;
    int                    requests_sent = 0;
    int                    results_checked = 0;
    int                    peak_len = 0;
    int                    stat_count [4] = '{0, 0, 0, 0};
    bit                    quiet = 1'b0;   // both sides run without idling
    int                    rx_stall;

    positional_list_engine_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the list model and return the result it yields.
    function automatic list_result_t list_apply(input logic [2:0] kind,
                                                input logic [31:0] value,
                                                input logic [6:0] pos);
        list_result_t r;
        int           p;
        int           i;
        r.rd_val = '0;
        r.stat   = ple_pkg::STAT_OK;
        p        = int'(pos);
        case (kind)
            ple_pkg::KIND_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.stat = ple_pkg::STAT_FULL;
                end else begin
                    list_mem[list_len] = value;
                    list_len++;
                end
            end
            ple_pkg::KIND_INSERT: begin
                // bad position wins over full
                if (p > list_len) begin
                    r.stat = ple_pkg::STAT_BADPOS;
                end else if (list_len >= DEPTH) begin
                    r.stat = ple_pkg::STAT_FULL;
                end else begin
                    for (i = list_len; i > p; i--) list_mem[i] = list_mem[i - 1];
                    list_mem[p] = value;
                    list_len++;
                end
            end
            ple_pkg::KIND_REM_TAIL: begin
                if (list_len == 0) begin
                    r.stat = ple_pkg::STAT_EMPTY;
                end else begin
                    r.rd_val = list_mem[list_len - 1];
                    list_len--;
                end
            end
            ple_pkg::KIND_REM_AT: begin
                if (list_len == 0) begin
                    r.stat = ple_pkg::STAT_EMPTY;
                end else if (p >= list_len) begin
                    r.stat = ple_pkg::STAT_BADPOS;
                end else begin
                    r.rd_val = list_mem[p];
                    for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            ple_pkg::KIND_RD_HEAD, ple_pkg::KIND_RD_TAIL: begin
                if (list_len == 0) begin
                    r.stat = ple_pkg::STAT_EMPTY;
                end else if (p >= list_len) begin
                    r.stat = ple_pkg::STAT_BADPOS;
                end else if (kind == ple_pkg::KIND_RD_HEAD) begin
                    r.rd_val = list_mem[p];
                end else begin
                    r.rd_val = list_mem[list_len - 1 - p];
                end
            end
            ple_pkg::KIND_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        r.len = list_len[6:0];
        return r;
    endfunction

    // Append one row to the directed table; want_* only matter when typed.
    task automatic add_row(input logic [2:0] kind, input logic [31:0] value,
                           input logic [6:0] pos, input logic typed,
                           input logic [31:0] want_val, input logic [1:0] want_stat,
                           input logic [6:0] want_len);
        request_row_t row;
        row.kind        = kind;
        row.value       = value;
        row.pos         = pos;
        row.typed       = typed;
        row.want.rd_val = want_val;
        row.want.stat   = want_stat;
        row.want.len    = want_len;
        request_table.push_back(row);
    endtask

    // Drive one request at the falling edge and hold it until the transfer.
    task automatic send_request(input logic [2:0] kind, input logic [31:0] value,
                                input logic [6:0] pos, input logic typed,
                                input list_result_t want);
        list_result_t predicted;
        int           gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, pos, value, kind};
        do @(posedge aclk); while (!s_tready);
        predicted = list_apply(kind, value, pos);
        if (typed) predicted = want;
        pending_results.push_back(predicted);
        stat_count[predicted.stat]++;
        requests_sent++;
        if (list_len > peak_len) peak_len = list_len;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: v = 32'h7FFF_FFFF;
                1: v = 32'h8000_0000;
                2: v = 32'h0000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end
        return v;
    endfunction

    // Valid index below bound; an occasional wild pick anywhere in 0..127.
    function automatic logic [6:0] pick_pos(input int bound, input int wild_pct);
        if (bound <= 0 || $urandom_range(0, 99) < wild_pct) return 7'($urandom_range(0, 127));
        return 7'($urandom_range(0, bound - 1));
    endfunction

    // Random phases: fill to full, drain to empty, mixed traffic and noise.
    task automatic run_random();
        phase_t       ph;
        int           budget;
        int           extra;
        int           roll;
        logic [2:0]   kind;
        logic [31:0]  value;
        logic [6:0]   pos;
        list_result_t none;
        none = '0;
        ph   = PH_FILL;     // open with a fill so the full flag shows early
        while (requests_sent < RANDOM_ITEMS + request_table.size()) begin
            quiet  = ($urandom_range(0, 3) == 0);
            budget = $urandom_range(20, 80);
            extra  = $urandom_range(2, 6);
            while (budget > 0 || (ph == PH_FILL && list_len < DEPTH)
                   || (ph == PH_DRAIN && list_len > 0) || extra > 0) begin
                if (budget > 0) budget--;
                else if ((ph != PH_FILL || list_len == DEPTH)
                         && (ph != PH_DRAIN || list_len == 0)) extra--;
                roll  = $urandom_range(0, 99);
                value = pick_value();
                case (ph)
                    PH_FILL: begin
                        if (roll < 55)      kind = ple_pkg::KIND_APPEND;
                        else if (roll < 90) kind = ple_pkg::KIND_INSERT;
                        else if (roll < 95) kind = ple_pkg::KIND_RD_HEAD;
                        else                kind = ple_pkg::KIND_RD_TAIL;
                        pos = pick_pos(kind == ple_pkg::KIND_INSERT ? list_len + 1
                                                                    : list_len, 3);
                    end
                    PH_DRAIN: begin
                        if (roll < 45)      kind = ple_pkg::KIND_REM_TAIL;
                        else if (roll < 85) kind = ple_pkg::KIND_REM_AT;
                        else if (roll < 93) kind = ple_pkg::KIND_RD_HEAD;
                        else                kind = ple_pkg::KIND_RD_TAIL;
                        pos = pick_pos(list_len, 3);
                    end
                    PH_MIX: begin
                        if (roll < 20)      kind = ple_pkg::KIND_APPEND;
                        else if (roll < 40) kind = ple_pkg::KIND_INSERT;
                        else if (roll < 55) kind = ple_pkg::KIND_REM_TAIL;
                        else if (roll < 70) kind = ple_pkg::KIND_REM_AT;
                        else if (roll < 80) kind = ple_pkg::KIND_RD_HEAD;
                        else if (roll < 92) kind = ple_pkg::KIND_RD_TAIL;
                        else if (roll < 95) kind = ple_pkg::KIND_CLEAR;
                        else                kind = KIND_NOP;
                        pos = pick_pos(kind == ple_pkg::KIND_INSERT ? list_len + 1
                                                                    : list_len, 15);
                    end
                    default: begin
                        kind = 3'($urandom_range(0, 7));
                        pos  = 7'($urandom_range(0, 127));
                    end
                endcase
                send_request(kind, value, pos, 1'b0, none);
            end
            roll = $urandom_range(0, 99);
            if (roll < 25)      ph = PH_FILL;
            else if (roll < 50) ph = PH_DRAIN;
            else if (roll < 90) ph = PH_MIX;
            else                ph = PH_NOISE;
        end
    endtask

    // Result side: random back-pressure, then compare against the oldest
    // expectation.
    initial begin : result_monitor
        list_result_t want;
        logic [31:0]  got_val;
        logic [1:0]   got_stat;
        logic [6:0]   got_len;
        wait (aresetn === 1'b1);
        forever begin
            rx_stall = quiet ? 0 : $urandom_range(0, 10);
            repeat (rx_stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got_val  = m_tdata[31:0];
            got_stat = m_tdata[33:32];
            got_len  = m_tdata[40:34];
            results_checked++;
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: read_value %0d status %0d length %0d",
                       $signed(got_val), got_stat, got_len);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got_val !== want.rd_val) begin
                    $error("read_value mismatch: expected %0d, actual %0d",
                           $signed(want.rd_val), $signed(got_val));
                    errors++;
                end
                if (got_stat !== want.stat) begin
                    $error("status mismatch: expected %0d, actual %0d", want.stat, got_stat);
                    errors++;
                end
                if (got_len !== want.len) begin
                    $error("length mismatch: expected %0d, actual %0d", want.len, got_len);
                    errors++;
                end
            end
        end
    end

    // Request side and end of run.
    initial begin : request_driver
        request_row_t row;
        // empty list: every removal and read reports empty
        add_row(ple_pkg::KIND_REM_TAIL, 32'h0, 7'd0, 1'b1, 32'h0, ple_pkg::STAT_EMPTY, 7'd0);
        add_row(ple_pkg::KIND_REM_AT, 32'h0, 7'd0, 1'b1, 32'h0, ple_pkg::STAT_EMPTY, 7'd0);
        add_row(ple_pkg::KIND_RD_HEAD, 32'h0, 7'd0, 1'b1, 32'h0, ple_pkg::STAT_EMPTY, 7'd0);
        add_row(ple_pkg::KIND_RD_TAIL, 32'hFFFF_FFFF, 7'd127, 1'b1, 32'h0,
                ple_pkg::STAT_EMPTY, 7'd0);
        // insert past the end of an empty list, clear of an empty list
        add_row(ple_pkg::KIND_INSERT, 32'h5, 7'd1, 1'b1, 32'h0, ple_pkg::STAT_BADPOS, 7'd0);
        add_row(ple_pkg::KIND_CLEAR, 32'h0, 7'd0, 1'b1, 32'h0, ple_pkg::STAT_OK, 7'd0);
        // insert into empty list, append, insert at the end acts as append
        add_row(ple_pkg::KIND_INSERT, 32'h7FFF_FFFF, 7'd0, 1'b1, 32'h0, ple_pkg::STAT_OK, 7'd1);
        add_row(ple_pkg::KIND_APPEND, 32'h8000_0000, 7'd127, 1'b1, 32'h0,
                ple_pkg::STAT_OK, 7'd2);
        add_row(ple_pkg::KIND_INSERT, 32'hFFFF_FFFF, 7'd2, 1'b1, 32'h0, ple_pkg::STAT_OK, 7'd3);
        add_row(ple_pkg::KIND_RD_HEAD, 32'h0, 7'd0, 1'b1, 32'h7FFF_FFFF,
                ple_pkg::STAT_OK, 7'd3);
        add_row(ple_pkg::KIND_RD_TAIL, 32'h0, 7'd0, 1'b1, 32'hFFFF_FFFF,
                ple_pkg::STAT_OK, 7'd3);
        // positions at and beyond the length
        add_row(ple_pkg::KIND_RD_HEAD, 32'h0, 7'd3, 1'b1, 32'h0, ple_pkg::STAT_BADPOS, 7'd3);
        add_row(ple_pkg::KIND_RD_TAIL, 32'h0, 7'd127, 1'b1, 32'h0,
                ple_pkg::STAT_BADPOS, 7'd3);
        add_row(ple_pkg::KIND_INSERT, 32'h4, 7'd4, 1'b1, 32'h0, ple_pkg::STAT_BADPOS, 7'd3);
        // middle insert, reads and removal: left to the model
        add_row(ple_pkg::KIND_INSERT, 32'h5A5A_5A5A, 7'd1, 1'b0, 32'h0,
                ple_pkg::STAT_OK, 7'd0);
        add_row(ple_pkg::KIND_RD_HEAD, 32'h0, 7'd1, 1'b0, 32'h0, ple_pkg::STAT_OK, 7'd0);
        add_row(ple_pkg::KIND_RD_TAIL, 32'h0, 7'd2, 1'b0, 32'h0, ple_pkg::STAT_OK, 7'd0);
        add_row(ple_pkg::KIND_REM_AT, 32'h0, 7'd4, 1'b1, 32'h0, ple_pkg::STAT_BADPOS, 7'd4);
        add_row(ple_pkg::KIND_REM_AT, 32'h0, 7'd1, 1'b0, 32'h0, ple_pkg::STAT_OK, 7'd0);
        // removals return the removed value
        add_row(ple_pkg::KIND_REM_AT, 32'h0, 7'd0, 1'b1, 32'h7FFF_FFFF,
                ple_pkg::STAT_OK, 7'd2);
        add_row(ple_pkg::KIND_REM_TAIL, 32'h0, 7'd0, 1'b1, 32'hFFFF_FFFF,
                ple_pkg::STAT_OK, 7'd1);
        // unused kind does nothing
        add_row(KIND_NOP, 32'hDEAD_BEEF, 7'd127, 1'b1, 32'h0, ple_pkg::STAT_OK, 7'd1);
        add_row(ple_pkg::KIND_REM_TAIL, 32'h0, 7'd0, 1'b1, 32'h8000_0000,
                ple_pkg::STAT_OK, 7'd0);
        add_row(ple_pkg::KIND_APPEND, 32'h0, 7'd0, 1'b1, 32'h0, ple_pkg::STAT_OK, 7'd1);
        add_row(ple_pkg::KIND_CLEAR, 32'h0, 7'd0, 1'b1, 32'h0, ple_pkg::STAT_OK, 7'd0);

        // hold reset, then release it on a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (request_table[i]) begin
            row = request_table[i];
            send_request(row.kind, row.value, row.pos, row.typed, row.want);
        end
        run_random();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // leave room for any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d requests and %0d result transfers; peak length %0d of %0d.",
                 requests_sent, results_checked, peak_len, DEPTH);
        $display("Status mix: ok %0d, empty %0d, bad position %0d, full %0d.",
                 stat_count[ple_pkg::STAT_OK], stat_count[ple_pkg::STAT_EMPTY],
                 stat_count[ple_pkg::STAT_BADPOS], stat_count[ple_pkg::STAT_FULL]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest correct run (every request a full
    // shift with both sides at their longest idle).
    initial begin : watchdog
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
